[hdl/epmc_pkg.sv]
// shared types, widths and codes for the encoder proportional move controller
// no dependencies; imported by epmc_div and the top level
package epmc_pkg;

    // encoder count width taken from each sample
    localparam int COUNT_BITS = 32;
    localparam int IN_W       = 32;
    localparam int TGT_W      = 16;
    localparam int SPD_W      = 8;
    localparam int DRV_W      = 8;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;

    // signed error, product and numerator widths
    localparam int ERR_W  = COUNT_BITS + 2;
    localparam int PROD_W = ERR_W + SPD_W;
    localparam int NUM_W  = PROD_W + 1;

    // quotient magnitude bits; all ones is the saturated drive
    localparam int QUOT_W = DRV_W - 1;
    localparam int STEP_W = $clog2(QUOT_W + 1);

    localparam logic [1:0] MODE_STRAIGHT = 2'd0;
    localparam logic [1:0] MODE_LEFT     = 2'd1;
    localparam logic [1:0] MODE_RIGHT    = 2'd2;
    localparam logic [1:0] MODE_END      = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED  = 2'd2;

    localparam logic [1:0]       MODE_RESET   = MODE_STRAIGHT;
    localparam logic [TGT_W-1:0] TARGET_RESET = 16'd1000;
    localparam logic [SPD_W-1:0] SPEED_RESET  = 8'sd127;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRAVEL,
        ST_MULT,
        ST_LOAD,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_stat_t;

endpackage

[hdl/epmc_div.sv]
// shared restoring divider, one compare and subtract per cycle
// quotient saturates to all ones when it would not fit; uses epmc_pkg
module epmc_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [epmc_pkg::NUM_W-1:0] dividend,
    input  logic [epmc_pkg::TGT_W-1:0] divisor,
    output epmc_pkg::div_stat_t        stat
);
    import epmc_pkg::*;

    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [NUM_W-1:0]  trial;
    logic              ge;

    // divisor scaled by the current quotient bit weight
    assign trial = NUM_W'(divisor) << step_reg;
    assign ge    = (rem_reg >= trial);

    always_comb
    begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend;
            quot_next = '0;
            step_next = STEP_W'(QUOT_W);
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            if (step_reg == STEP_W'(QUOT_W))
            begin
                // overflow check against the first weight past the quotient
                if (ge)
                begin
                    quot_next = '1;
                    run_next  = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            else
            begin
                if (ge)
                begin
                    rem_next = rem_reg - trial;
                end
                quot_next = {quot_reg[QUOT_W-2:0], ge};
                if (step_reg == '0)
                begin
                    run_next  = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign stat.done = done_reg;
    assign stat.quot = quot_reg;

endmodule

[hdl/encoder_proportional_move_controller_core.sv]
// top level of the two-wheel proportional encoder move controller
// uses epmc_pkg and the shared divider epmc_div
//
// Each input item is one encoder sample for both wheels; each item yields exactly one result
// item with a signed drive per wheel and a done flag. An item with start_move set takes its
// counts as the origin and is evaluated at zero travel. For an active move the drive of each
// wheel is trunc(((target - travel) * speed + target) / target), saturated to +/-127, with the
// sign chosen by move_mode and reversed once both wheels have passed the target. When both
// travels equal the target exactly the move ends: drives 0 and move_done 1, as for every item
// while no move is running. Mode 3 ends a move at once. A target of 0 acts as 1. The block
// takes one item at a time: in_stall is high from acceptance until the result is loaded into
// the output register. An active sample runs a multiply and an 8-step divide per wheel on the
// single shared divider, cut short when a drive saturates; an idle, finished or ending sample
// skips both. A result waiting at the output does not block acceptance of the next item.
// Configuration must be written only while the block is idle; the block does not enforce it.
module encoder_proportional_move_controller_core (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [epmc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [epmc_pkg::CFG_W-1:0]     cfg_data,
    // sample channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           start_move,
    input  logic signed [epmc_pkg::IN_W-1:0] left_count,
    input  logic signed [epmc_pkg::IN_W-1:0] right_count,
    // result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [epmc_pkg::DRV_W-1:0] left_drive,
    output logic signed [epmc_pkg::DRV_W-1:0] right_drive,
    output logic                           move_done
);
    import epmc_pkg::*;

    // configuration registers
    logic [1:0]       mode_reg;
    logic [TGT_W-1:0] target_reg;
    logic [SPD_W-1:0] speed_reg;

    // sequencer
    state_t state_reg, state_next;
    logic   wheel_reg, wheel_next;     // 0 left, 1 right

    // move state
    logic signed [COUNT_BITS-1:0] origin_l_reg, origin_l_next;
    logic signed [COUNT_BITS-1:0] origin_r_reg, origin_r_next;
    logic                         finished_reg, finished_next;

    // per-item working registers
    logic signed [COUNT_BITS-1:0] cnt_l_reg, cnt_l_next;
    logic signed [COUNT_BITS-1:0] cnt_r_reg, cnt_r_next;
    logic [COUNT_BITS-1:0]        dl_reg, dl_next;
    logic [COUNT_BITS-1:0]        dr_reg, dr_next;
    logic                         over_reg, over_next;
    logic signed [NUM_W-1:0]      num_reg, num_next;
    logic signed [DRV_W-1:0]      res_l_reg, res_l_next;
    logic signed [DRV_W-1:0]      res_r_reg, res_r_next;
    logic                         res_done_reg, res_done_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic signed [DRV_W-1:0] left_drive_reg, left_drive_next;
    logic signed [DRV_W-1:0] right_drive_reg, right_drive_next;
    logic                    move_done_reg, move_done_next;

    // datapath signals
    logic                         in_acc;
    logic                         out_free;
    logic                         fin_acc;
    logic [TGT_W-1:0]             tgt_eff;
    logic signed [COUNT_BITS:0]   diff_l, diff_r;
    logic [COUNT_BITS-1:0]        trav_l, trav_r;
    logic                         at_target;
    logic [COUNT_BITS-1:0]        d_sel;
    logic signed [ERR_W-1:0]      err;
    logic signed [PROD_W-1:0]     prod;
    logic [NUM_W-1:0]             num_mag;
    logic                         flip;
    logic signed [DRV_W-1:0]      quot_ext;
    logic signed [DRV_W-1:0]      drive_val;
    logic                         div_start;
    div_stat_t                    div_stat;

    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE);

    // a zero target behaves as one
    assign tgt_eff = (target_reg == '0) ? TGT_W'(1) : target_reg;

    // finished flag as seen by the item being accepted; the unused mode ends any move
    assign fin_acc = start_move ? (mode_reg == MODE_END) :
                                  (finished_reg || (mode_reg == MODE_END));

    // absolute travel from the origin, exact over the full count range
    assign diff_l    = (COUNT_BITS + 1)'(cnt_l_reg) - (COUNT_BITS + 1)'(origin_l_reg);
    assign diff_r    = (COUNT_BITS + 1)'(cnt_r_reg) - (COUNT_BITS + 1)'(origin_r_reg);
    assign trav_l    = diff_l[COUNT_BITS] ? COUNT_BITS'(-diff_l) : diff_l[COUNT_BITS-1:0];
    assign trav_r    = diff_r[COUNT_BITS] ? COUNT_BITS'(-diff_r) : diff_r[COUNT_BITS-1:0];
    assign at_target = (trav_l == COUNT_BITS'(tgt_eff)) && (trav_r == COUNT_BITS'(tgt_eff));

    // numerator (target - travel) * speed + target for the wheel in work
    assign d_sel = wheel_reg ? dr_reg : dl_reg;
    assign err   = $signed(ERR_W'(tgt_eff)) - $signed(ERR_W'(d_sel));
    assign prod  = err * $signed(speed_reg);

    assign num_mag = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);

    // drive sign: numerator sign, then the mode's turn direction and overshoot reversal
    always_comb
    begin
        if (!wheel_reg)
        begin
            flip = (mode_reg == MODE_LEFT) ? !over_reg : over_reg;
        end
        else
        begin
            flip = (mode_reg == MODE_RIGHT) ? !over_reg : over_reg;
        end
    end

    assign quot_ext  = $signed({1'b0, div_stat.quot});
    assign drive_val = (num_reg[NUM_W-1] ^ flip) ? -quot_ext : quot_ext;

    epmc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_mag),
        .divisor  (tgt_eff),
        .stat     (div_stat)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = fin_acc ? ST_FINISH : ST_TRAVEL;
                end
            end
            ST_TRAVEL:
            begin
                state_next = at_target ? ST_FINISH : ST_MULT;
            end
            ST_MULT:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = wheel_reg ? ST_FINISH : ST_MULT;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and output register updates
    always_comb
    begin
        wheel_next       = wheel_reg;
        origin_l_next    = origin_l_reg;
        origin_r_next    = origin_r_reg;
        finished_next    = finished_reg;
        cnt_l_next       = cnt_l_reg;
        cnt_r_next       = cnt_r_reg;
        dl_next          = dl_reg;
        dr_next          = dr_reg;
        over_next        = over_reg;
        num_next         = num_reg;
        res_l_next       = res_l_reg;
        res_r_next       = res_r_reg;
        res_done_next    = res_done_reg;
        left_drive_next  = left_drive_reg;
        right_drive_next = right_drive_reg;
        move_done_next   = move_done_reg;
        out_valid_next   = out_valid_reg && out_stall;
        div_start        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    cnt_l_next = left_count[COUNT_BITS-1:0];
                    cnt_r_next = right_count[COUNT_BITS-1:0];
                    if (start_move)
                    begin
                        origin_l_next = left_count[COUNT_BITS-1:0];
                        origin_r_next = right_count[COUNT_BITS-1:0];
                    end
                    finished_next = fin_acc;
                    res_l_next    = '0;
                    res_r_next    = '0;
                    res_done_next = fin_acc;
                end
            end
            ST_TRAVEL:
            begin
                dl_next    = trav_l;
                dr_next    = trav_r;
                over_next  = (trav_l > COUNT_BITS'(tgt_eff)) && (trav_r > COUNT_BITS'(tgt_eff));
                wheel_next = 1'b0;
                if (at_target)
                begin
                    finished_next = 1'b1;
                    res_done_next = 1'b1;
                end
            end
            ST_MULT:
            begin
                num_next = NUM_W'(prod) + $signed(NUM_W'(tgt_eff));
            end
            ST_LOAD:
            begin
                div_start = 1'b1;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    if (!wheel_reg)
                    begin
                        res_l_next = drive_val;
                    end
                    else
                    begin
                        res_r_next = drive_val;
                    end
                    wheel_next = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    left_drive_next  = res_l_reg;
                    right_drive_next = res_r_reg;
                    move_done_next   = res_done_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // configuration registers, to be written only while idle; the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_RESET;
            target_reg <= TARGET_RESET;
            speed_reg  <= SPEED_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:   mode_reg   <= cfg_data[1:0];
                REG_TARGET: target_reg <= cfg_data[TGT_W-1:0];
                REG_SPEED:  speed_reg  <= cfg_data[SPD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // control and move state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wheel_reg     <= 1'b0;
            origin_l_reg  <= '0;
            origin_r_reg  <= '0;
            finished_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wheel_reg     <= wheel_next;
            origin_l_reg  <= origin_l_next;
            origin_r_reg  <= origin_r_next;
            finished_reg  <= finished_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cnt_l_reg       <= cnt_l_next;
        cnt_r_reg       <= cnt_r_next;
        dl_reg          <= dl_next;
        dr_reg          <= dr_next;
        over_reg        <= over_next;
        num_reg         <= num_next;
        res_l_reg       <= res_l_next;
        res_r_reg       <= res_r_next;
        res_done_reg    <= res_done_next;
        left_drive_reg  <= left_drive_next;
        right_drive_reg <= right_drive_next;
        move_done_reg   <= move_done_next;
    end

    assign out_valid   = out_valid_reg;
    assign left_drive  = left_drive_reg;
    assign right_drive = right_drive_reg;
    assign move_done   = move_done_reg;

    // a finished move never drives the motors
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && move_done |-> (left_drive == '0) && (right_drive == '0))
        else $error("done result with nonzero drive");

    // saturation keeps drives symmetric
    a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (left_drive != {1'b1, {(DRV_W-1){1'b0}}}) &&
                      (right_drive != {1'b1, {(DRV_W-1){1'b0}}}))
        else $error("drive outside the saturated range");

    // the divider only reports while the sequencer waits for it
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider result outside the divide step");

    // an accepted item always occupies the sequencer
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg != ST_IDLE))
        else $error("sequencer idle after accepting an item");

    // a result is loaded only from the finish step
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_FINISH))
        else $error("result loaded outside the finish step");

endmodule

[verif/epmc_drive_checker.sv]
`timescale 1ns / 1ps
// scoreboard for the encoder proportional move controller: mirrors config writes,
// predicts each result item from accepted samples and compares in order; uses epmc_pkg
module epmc_drive_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [epmc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [epmc_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic                               start_move,
    input  logic signed [epmc_pkg::IN_W-1:0]   left_count,
    input  logic signed [epmc_pkg::IN_W-1:0]   right_count,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic signed [epmc_pkg::DRV_W-1:0]  left_drive,
    input  logic signed [epmc_pkg::DRV_W-1:0]  right_drive,
    input  logic                               move_done,
    output int                                 expected_left,
    output int                                 errors
);
    import epmc_pkg::*;

    typedef struct packed {
        logic signed [DRV_W-1:0] left_drv;
        logic signed [DRV_W-1:0] right_drv;
        logic                    done;
    } drive_result_t;

    drive_result_t pending_drives[$];

    // mirrored registers and move state
    logic [1:0]              mode_reg;
    logic [TGT_W-1:0]        target_reg;
    logic signed [SPD_W-1:0] speed_reg;
    longint                  origin_l;
    longint                  origin_r;
    logic                    move_idle;

    initial errors = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    // low COUNT_BITS bits of a count, sign extended
    function automatic longint count_signed(input logic [IN_W-1:0] raw);
        longint v;
        v = longint'(raw);
        v = v <<< (64 - COUNT_BITS);
        return v >>> (64 - COUNT_BITS);
    endfunction

    function automatic longint drive_level(input longint tgt, input longint trav,
                                           input longint spd);
        longint q;
        q = ((tgt - trav) * spd + tgt) / tgt;
        if (q > 127)
            q = 127;
        if (q < -127)
            q = -127;
        return q;
    endfunction

    task automatic predict_drive(input logic start, input logic [IN_W-1:0] lraw,
                                 input logic [IN_W-1:0] rraw);
        longint        cl, cr, tgt, spd, dl, dr, vl, vr, l, r;
        logic          over;
        drive_result_t res;
        cl  = count_signed(lraw);
        cr  = count_signed(rraw);
        tgt = longint'(target_reg);
        spd = longint'(speed_reg);
        res = '0;
        if (start)
        begin
            origin_l  = cl;
            origin_r  = cr;
            move_idle = 1'b0;
        end
        if (tgt == 0)
            tgt = 1;
        if (!move_idle && mode_reg == MODE_END)
            move_idle = 1'b1;
        if (!move_idle)
        begin
            dl = cl - origin_l;
            dr = cr - origin_r;
            if (dl < 0)
                dl = -dl;
            if (dr < 0)
                dr = -dr;
            if (dl == tgt && dr == tgt)
            begin
                move_idle = 1'b1;
            end
            else
            begin
                vl   = drive_level(tgt, dl, spd);
                vr   = drive_level(tgt, dr, spd);
                over = (dl > tgt) && (dr > tgt);
                case (mode_reg)
                    MODE_STRAIGHT:
                    begin
                        l = over ? -vl : vl;
                        r = over ? -vr : vr;
                    end
                    MODE_LEFT:
                    begin
                        l = over ? vl : -vl;
                        r = over ? -vr : vr;
                    end
                    default:
                    begin
                        l = over ? -vl : vl;
                        r = over ? vr : -vr;
                    end
                endcase
                res.left_drv  = DRV_W'(l);
                res.right_drv = DRV_W'(r);
            end
        end
        res.done = move_idle;
        pending_drives.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   = MODE_RESET;
            target_reg = TARGET_RESET;
            speed_reg  = SPEED_RESET;
            origin_l   = 0;
            origin_r   = 0;
            move_idle  = 1'b1;
            pending_drives.delete();
            expected_left <= 0;
        end
        else
        begin : watch
            drive_result_t want;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MODE:   mode_reg   = cfg_data[1:0];
                    REG_TARGET: target_reg = cfg_data[TGT_W-1:0];
                    REG_SPEED:  speed_reg  = cfg_data[SPD_W-1:0];
                    default:    ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (pending_drives.size() == 0)
                begin
                    report_mismatch($sformatf("result item with none expected: %0d %0d %0b",
                                              left_drive, right_drive, move_done));
                end
                else
                begin
                    want = pending_drives.pop_front();
                    if (left_drive !== want.left_drv)
                        report_mismatch($sformatf("left_drive got %0d expected %0d",
                                                  left_drive, $signed(want.left_drv)));
                    if (right_drive !== want.right_drv)
                        report_mismatch($sformatf("right_drive got %0d expected %0d",
                                                  right_drive, $signed(want.right_drv)));
                    if (move_done !== want.done)
                        report_mismatch($sformatf("move_done got %0b expected %0b",
                                                  move_done, want.done));
                end
            end
            if (in_valid && !in_stall)
                predict_drive(start_move, left_count, right_count);
            expected_left <= pending_drives.size();
        end
    end

endmodule

[verif/tb_encoder_proportional_move_controller_core.sv]
`timescale 1ns / 1ps
// testbench top for encoder_proportional_move_controller_core: clock, reset, stimulus
// and verdict; relies on epmc_pkg and the epmc_drive_checker scoreboard
module tb_encoder_proportional_move_controller_core;
    import epmc_pkg::*;

    // roughly how many random sample items to send after the directed part
    localparam int RANDOM_ITEMS = 1500;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_W-1:0]         cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic                     start_move;
    logic signed [IN_W-1:0]   left_count;
    logic signed [IN_W-1:0]   right_count;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [DRV_W-1:0]  left_drive;
    logic signed [DRV_W-1:0]  right_drive;
    logic                     move_done;

    int                       expected_left;
    int                       mismatch_count;
    int                       sent_count;
    int                       stall_hold;
    logic [TGT_W-1:0]         cur_target;

    encoder_proportional_move_controller_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .start_move (start_move),
        .left_count (left_count),
        .right_count(right_count),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .left_drive (left_drive),
        .right_drive(right_drive),
        .move_done  (move_done)
    );

    // predicts and compares every result item, reports the failure count back here
    epmc_drive_checker drive_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .start_move   (start_move),
        .left_count   (left_count),
        .right_count  (right_count),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .left_drive   (left_drive),
        .right_drive  (right_drive),
        .move_done    (move_done),
        .expected_left(expected_left),
        .errors       (mismatch_count)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side back-pressure: short bursts mostly, some long stalls,
    // and some long stretches with no stall at all
    initial stall_hold = 0;
    always @(posedge clk)
    begin : stall_gen
        int r;
        if (stall_hold != 0)
        begin
            stall_hold--;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                out_stall  <= 1'b0;
                stall_hold = $urandom_range(0, 3);
            end
            else if (r < 85)
            begin
                out_stall  <= 1'b1;
                stall_hold = $urandom_range(0, 3);
            end
            else if (r < 93)
            begin
                out_stall  <= 1'b1;
                stall_hold = $urandom_range(10, 60);
            end
            else
            begin
                out_stall  <= 1'b0;
                stall_hold = $urandom_range(20, 200);
            end
        end
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #40_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // one sample item: random idle gap first, then hold until accepted
    task automatic send_sample(input logic start, input logic [IN_W-1:0] lc,
                               input logic [IN_W-1:0] rc);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 60);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        start_move  <= start;
        left_count  <= lc;
        right_count <= rc;
        do
            @(posedge clk);
        while (in_stall);
        sent_count++;
    endtask

    // registers only change once every result item has drained
    task automatic load_settings(input logic [1:0] mode, input logic [TGT_W-1:0] target,
                                 input logic [SPD_W-1:0] speed);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_left != 0);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MODE;
        cfg_data  <= CFG_W'(mode);
        @(posedge clk);
        cfg_index <= REG_TARGET;
        cfg_data  <= CFG_W'(target);
        @(posedge clk);
        cfg_index <= REG_SPEED;
        cfg_data  <= CFG_W'(speed);
        @(posedge clk);
        cfg_we     <= 1'b0;
        cur_target = target;
    endtask

    // origin counts: mostly random, sometimes the edges of the signed range, zero or minus one
    function automatic logic [IN_W-1:0] pick_count();
        case ($urandom_range(0, 19))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // a well formed move: start item, then samples whose travel ramps up,
    // hovers around the target, overshoots, or jumps wildly
    task automatic run_move(input int n_samples, input bit end_exact);
        logic [IN_W-1:0] ol, orr;
        longint          eff, tl, tr;
        int              dir_l, dir_r, r;
        eff   = (cur_target == 0) ? 1 : cur_target;
        ol    = pick_count();
        orr   = pick_count();
        dir_l = $urandom_range(0, 1) ? 1 : -1;
        dir_r = $urandom_range(0, 1) ? 1 : -1;
        send_sample(1'b1, ol, orr);
        for (int i = 1; i <= n_samples; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                // approach
                tl = eff * i / (n_samples + 1) + $urandom_range(0, 4) - 2;
                tr = eff * i / (n_samples + 1) + $urandom_range(0, 4) - 2;
            end
            else if (r < 70)
            begin
                // right around the target
                tl = eff + $urandom_range(0, 4) - 2;
                tr = eff + $urandom_range(0, 4) - 2;
            end
            else if (r < 85)
            begin
                // both wheels past the target
                tl = eff + 1 + $urandom_range(0, int'(eff));
                tr = eff + 1 + $urandom_range(0, int'(eff));
            end
            else if (r < 93)
            begin
                // one wheel exactly there, the other anywhere
                tl = eff;
                tr = $urandom_range(0, 2 * int'(eff));
            end
            else
            begin
                tl = $urandom();
                tr = $urandom();
            end
            if (tl < 0)
                tl = 0;
            if (tr < 0)
                tr = 0;
            send_sample(1'b0, ol + IN_W'(dir_l * tl), orr + IN_W'(dir_r * tr));
        end
        if (end_exact)
        begin
            send_sample(1'b0, ol + IN_W'(dir_l * eff), orr + IN_W'(dir_r * eff));
            if ($urandom_range(0, 1))
                send_sample(1'b0, $urandom(), $urandom());
        end
    endtask

    initial
    begin : stimulus
        logic [1:0]       mode;
        logic [TGT_W-1:0] target;
        logic [SPD_W-1:0] speed;
        int               r;
        int               stop_at;

        // every input known from time zero
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_MODE;
        cfg_data    = '0;
        in_valid    = 1'b0;
        start_move  = 1'b0;
        left_count  = '0;
        right_count = '0;
        out_stall   = 1'b0;
        sent_count  = 0;
        cur_target  = TARGET_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, idle after reset, approach, one over,
        // both over (sign flip), exact finish, idle after finish
        send_sample(1'b0, 32'h7fff_ffff, 32'h8000_0000);
        send_sample(1'b1, 0, 0);
        send_sample(1'b0, 500, -500);
        send_sample(1'b0, 1000, 1001);
        send_sample(1'b0, 1001, -1001);
        send_sample(1'b0, 1000, -1000);
        send_sample(1'b0, 5, 5);

        // left turn, zero target acting as one, most negative speed,
        // origin at the count extremes so travel is the full span
        load_settings(MODE_LEFT, 16'd0, 8'h80);
        send_sample(1'b1, 32'h8000_0000, 32'h7fff_ffff);
        send_sample(1'b0, 32'h7fff_ffff, 32'h8000_0000);
        send_sample(1'b0, 32'h8000_0001, 32'h7fff_fffe);

        // right turn, largest target, speed -127
        load_settings(MODE_RIGHT, 16'hffff, 8'h81);
        send_sample(1'b1, 0, -1);
        send_sample(1'b0, 0, 65535);
        send_sample(1'b0, 70000, -70001);
        send_sample(1'b0, 65535, 65534);

        // unused mode ends the move on the start item itself
        load_settings(MODE_END, 16'd1, 8'h00);
        send_sample(1'b1, 123, 456);
        send_sample(1'b0, 124, 457);

        // smallest target with speed one: at rest, exact finish, overshoot
        load_settings(MODE_STRAIGHT, 16'd1, 8'h01);
        send_sample(1'b1, 0, 0);
        send_sample(1'b0, 1, -1);
        send_sample(1'b1, 0, 0);
        send_sample(1'b0, 2, 2);
        send_sample(1'b0, 32'h8000_0000, 32'h7fff_ffff);

        // unused mode selected while a move is still running ends it
        load_settings(MODE_END, 16'd1, 8'h01);
        send_sample(1'b0, 3, 3);
        send_sample(1'b0, 4, 4);

        // random phases, each with fresh settings and a few moves
        stop_at = sent_count + RANDOM_ITEMS;
        while (sent_count < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                mode = MODE_STRAIGHT;
            else if (r < 62)
                mode = MODE_LEFT;
            else if (r < 94)
                mode = MODE_RIGHT;
            else
                mode = MODE_END;

            r = $urandom_range(0, 99);
            if (r < 70)
                target = TGT_W'($urandom_range(1, 300));
            else if (r < 85)
                target = TGT_W'($urandom_range(301, 65535));
            else if (r < 90)
                target = 16'd0;
            else if (r < 95)
                target = 16'hffff;
            else
                target = 16'd1;

            case ($urandom_range(0, 9))
                0:       speed = 8'h7f;
                1:       speed = 8'h81;
                2:       speed = 8'h80;
                3:       speed = 8'h00;
                default: speed = SPD_W'($urandom_range(0, 255));
            endcase

            load_settings(mode, target, speed);
            repeat ($urandom_range(1, 4))
            begin
                run_move($urandom_range(2, 16), $urandom_range(0, 99) < 60);
                // occasional noise: random counts, sometimes a stray start
                repeat ($urandom_range(0, 2))
                    send_sample($urandom_range(0, 9) == 0, $urandom(), $urandom());
            end
        end

        // drain, then give the block time to show any stray result
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_left != 0);
        repeat (60) @(posedge clk);

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
